// ----- hdl/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon-with-holes block:
// request and response payloads, vertex word and the edge tag that rides
// along the crossing pipeline.
// ----------------------------------------------------------------------------
package pip_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic       mode;
      logic [2:0] ring;
      logic [5:0] vertex_index;
      logic       last_vertex;
      coord_type  coord_x;
      coord_type  coord_y;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic in_outer;
      logic in_hole;
   } rsp_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } vtx_type;

   // Tag carried with every pipeline slot.
   typedef struct packed {
      logic has_edge;   // previous and current vertex form an edge
      logic ring_end;   // last slot of the ring
      logic query_end;  // last slot of the query
      logic outer;      // slot belongs to ring 0
   } tag_type;

endpackage

// ----- hdl/pip_vram.sv -----
// ----------------------------------------------------------------------------
// pip_vram
// Vertex store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pip_vram
   import pip_pkg::*;
#(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  vtx_type       wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output vtx_type       rd_data
);

   vtx_type mem_ff [DEPTH];
   vtx_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/pip_xing.sv -----
// ----------------------------------------------------------------------------
// pip_xing
// Edge crossing test, three stages: differences and y range, products,
// signed sum and sign test. Keeps the previous vertex to pair with each new one.
// ----------------------------------------------------------------------------
module pip_xing
   import pip_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_vld,
   input  tag_type   in_tag,
   input  vtx_type   in_vtx,
   input  coord_type px,
   input  coord_type py,
   output logic      out_vld,
   output tag_type   out_tag,
   output logic      out_cross
);

   vtx_type prev_ff;

   // stage 0
   logic                        s0_vld_ff, s0_hit_ff, s0_dpos_ff;
   tag_type                     s0_tag_ff;
   logic signed [DIFF_BITS-1:0] a_ff, b_ff, c_ff, d_ff;
   logic signed [DIFF_BITS-1:0] a_in, b_in, c_in, d_in;
   logic                        hit_in, dpos_in;
   // stage 1
   logic                        s1_vld_ff, s1_hit_ff, s1_dpos_ff;
   tag_type                     s1_tag_ff;
   logic signed [PROD_BITS-1:0] p1_ff, p2_ff;
   // stage 2
   logic                        s2_vld_ff, s2_cross_ff;
   tag_type                     s2_tag_ff;
   logic signed [SUM_BITS-1:0]  t_in;
   logic                        cross_in;

   always_comb begin
      a_in    = DIFF_BITS'(prev_ff.x) - DIFF_BITS'(px);
      b_in    = DIFF_BITS'(in_vtx.x) - DIFF_BITS'(prev_ff.x);
      c_in    = DIFF_BITS'(py) - DIFF_BITS'(prev_ff.y);
      d_in    = DIFF_BITS'(in_vtx.y) - DIFF_BITS'(prev_ff.y);
      dpos_in = in_vtx.y > prev_ff.y;
      // half-open range; empty for a horizontal edge
      if (dpos_in) begin
         hit_in = (py >= prev_ff.y) && (py < in_vtx.y);
      end else begin
         hit_in = (py >= in_vtx.y) && (py < prev_ff.y);
      end
      hit_in = hit_in && in_tag.has_edge;
   end

   always_comb begin
      t_in = SUM_BITS'(p1_ff) + SUM_BITS'(p2_ff);
      if (s1_dpos_ff) begin
         cross_in = s1_hit_ff && (t_in > 0);
      end else begin
         cross_in = s1_hit_ff && (t_in < 0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= in_vld;
         s1_vld_ff <= s0_vld_ff;
         s2_vld_ff <= s1_vld_ff;
      end
      if (in_vld) begin
         prev_ff <= in_vtx;
      end
      s0_tag_ff   <= in_tag;
      s0_hit_ff   <= hit_in;
      s0_dpos_ff  <= dpos_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      d_ff        <= d_in;
      s1_tag_ff   <= s0_tag_ff;
      s1_hit_ff   <= s0_hit_ff;
      s1_dpos_ff  <= s0_dpos_ff;
      p1_ff       <= PROD_BITS'(a_ff) * PROD_BITS'(d_ff);
      p2_ff       <= PROD_BITS'(b_ff) * PROD_BITS'(c_ff);
      s2_tag_ff   <= s1_tag_ff;
      s2_cross_ff <= cross_in;
   end

   assign out_vld   = s2_vld_ff;
   assign out_tag   = s2_tag_ff;
   assign out_cross = s2_cross_ff;

endmodule

// ----- hdl/point_in_polygon_with_holes.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_with_holes
// Even-odd ray crossing test of a point against an outer ring and up to
// MAX_RINGS-1 hole rings held in an on-chip vertex store.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                        | Direction | Moves
//  --------+------------------------------+-----------+---------------------------
//  request | req_valid, req_stall, req_data | in      | vertex write or point query
//  result  | rsp_valid, rsp_stall, rsp_data | out     | one per query, none on write
//  csr     | csr_wr_en, csr_wr_data       | in        | ring_count
//
//  A vertex write does not make the block busy. A query walks each ring in
//  use, vertex 0..n-1 then vertex 0 again (a single slot for an empty ring),
//  then lets the crossing pipeline drain and loads the result register; the
//  single read port of the vertex store, one vertex per cycle, sets the pace
//  of the walk.
//  Reset clears ring lengths and sets ring_count to 1; the vertex store is not
//  cleared. A stalled result holds in its output register while the next
//  request is taken; a query finishing behind it waits.
// ----------------------------------------------------------------------------
module point_in_polygon_with_holes
   import pip_pkg::*;
#(
   parameter int MAX_RINGS      = 8,
   parameter int MAX_RING_VERTS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data
);

   localparam int DEPTH = MAX_RINGS * MAX_RING_VERTS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
   localparam int LW    = $clog2(MAX_RING_VERTS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_HOLD} state_type;

   state_type       state_ff, state_in;
   logic [RW-1:0]   ring_ff, ring_in;
   logic [RW-1:0]   last_ring_ff, last_ring_in;
   logic [LW-1:0]   pos_ff, pos_in;
   logic [AW-1:0]   base_ff, base_in;
   coord_type       px_ff, px_in, py_ff, py_in;
   logic            tok_vld_ff, tok_vld_in;
   tag_type         tok_ff, tok_in;
   logic            par_ff, par_in, outer_ff, outer_in, hole_ff, hole_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;
   logic [3:0]      ring_count_ff, ring_count_in;
   logic [LW-1:0]   len_ff [MAX_RINGS];
   logic [LW-1:0]   len_in [MAX_RINGS];

   logic            req_acc;
   logic            wr_en, rd_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   vtx_type         wr_data, rd_data;
   logic [LW-1:0]   cur_len, pos_sel;
   logic            ring_end, par_x;
   logic            x_vld, x_cross;
   tag_type         x_tag;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      ring_in       = ring_ff;
      last_ring_in  = last_ring_ff;
      pos_in        = pos_ff;
      base_in       = base_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      tok_vld_in    = 1'b0;
      tok_in        = '0;
      par_in        = par_ff;
      outer_in      = outer_ff;
      hole_in       = hole_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      ring_count_in = ring_count_ff;
      len_in        = len_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(int'(req_data.ring) * MAX_RING_VERTS + int'(req_data.vertex_index));
      wr_data       = '{x: req_data.coord_x, y: req_data.coord_y};
      rd_en         = 1'b0;
      cur_len       = len_ff[ring_ff];
      ring_end      = (pos_ff == cur_len);
      pos_sel       = ring_end ? '0 : pos_ff;
      rd_addr       = base_ff + AW'(pos_sel);

      if (csr_wr_en) begin
         ring_count_in = csr_wr_data;
      end

      // drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // fold crossings into the ring parity; close out each ring at its end
      par_x = par_ff ^ (x_vld && x_cross);
      if (x_vld) begin
         par_in = par_x;
         if (x_tag.ring_end) begin
            par_in = 1'b0;
            if (x_tag.outer) begin
               outer_in = par_x;
            end else begin
               hole_in = hole_ff | par_x;
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_data.mode == MODE_WRITE) begin
               // ignore writes outside the store
               if (int'(req_data.ring) < MAX_RINGS &&
                   int'(req_data.vertex_index) < MAX_RING_VERTS) begin
                  wr_en = 1'b1;
                  if (req_data.last_vertex) begin
                     len_in[RW'(req_data.ring)] = LW'(int'(req_data.vertex_index) + 1);
                  end
               end
            end else if (req_acc) begin
               px_in    = req_data.coord_x;
               py_in    = req_data.coord_y;
               ring_in  = '0;
               pos_in   = '0;
               base_in  = '0;
               par_in   = 1'b0;
               outer_in = 1'b0;
               hole_in  = 1'b0;
               // zero rings means one; saturate at the store size
               if (ring_count_ff == '0) begin
                  last_ring_in = '0;
               end else if (int'(ring_count_ff) > MAX_RINGS) begin
                  last_ring_in = RW'(MAX_RINGS - 1);
               end else begin
                  last_ring_in = RW'(ring_count_ff - 4'd1);
               end
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // walk vertex 0..n-1 then vertex 0 again to close the ring
            tok_vld_in   = 1'b1;
            tok_in.outer = (ring_ff == '0);
            if (cur_len == '0) begin
               tok_in.ring_end  = 1'b1;
               tok_in.query_end = (ring_ff == last_ring_ff);
            end else begin
               rd_en            = 1'b1;
               tok_in.has_edge  = (pos_ff != '0);
               tok_in.ring_end  = ring_end;
               tok_in.query_end = ring_end && (ring_ff == last_ring_ff);
            end
            if (cur_len == '0 || ring_end) begin
               pos_in  = '0;
               base_in = base_ff + AW'(MAX_RING_VERTS);
               if (ring_ff == last_ring_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  ring_in = ring_ff + RW'(1);
               end
            end else begin
               pos_in = pos_ff + LW'(1);
            end
         end
         ST_DRAIN: begin
            if (x_vld && x_tag.query_end) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // wait for a free output register
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.inside_res = outer_ff && !hole_ff;
               rsp_data_in.in_outer   = outer_ff;
               rsp_data_in.in_hole    = hole_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tok_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ring_count_ff <= 4'd1;
         for (int i = 0; i < MAX_RINGS; i++) begin
            len_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         tok_vld_ff    <= tok_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         ring_count_ff <= ring_count_in;
         len_ff        <= len_in;
      end
      ring_ff      <= ring_in;
      last_ring_ff <= last_ring_in;
      pos_ff       <= pos_in;
      base_ff      <= base_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      tok_ff       <= tok_in;
      par_ff       <= par_in;
      outer_ff     <= outer_in;
      hole_ff      <= hole_in;
      rsp_data_ff  <= rsp_data_in;
   end

   pip_vram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_vram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pip_xing u_xing (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (tok_vld_ff),
      .in_tag    (tok_ff),
      .in_vtx    (rd_data),
      .px        (px_ff),
      .py        (py_ff),
      .out_vld   (x_vld),
      .out_tag   (x_tag),
      .out_cross (x_cross)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hdl/pip_check.sv -----
// ----------------------------------------------------------------------------
// pip_check
// Port-level checks for point_in_polygon_with_holes, bound to the top level.
// ----------------------------------------------------------------------------
module pip_check
   import pip_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // a query occupies the block for at least the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.mode == MODE_QUERY |=> req_stall)
      else $error("request taken right after a query");

   // a vertex write leaves the block ready in the next cycle
   a_write_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.mode == MODE_WRITE |=> !req_stall)
      else $error("block busy after a vertex write");

   // inside is outer and not in any hole
   a_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.inside_res == (rsp_data.in_outer && !rsp_data.in_hole))
      else $error("inside flag inconsistent");

endmodule

bind point_in_polygon_with_holes pip_check u_pip_check (.*);

// ----- tb/tb_point_in_polygon_with_holes.sv -----
// ----------------------------------------------------------------------------
// tb_point_in_polygon_with_holes
// Self-checking bench for the point-in-polygon-with-holes block. Loads outer
// and hole rings through vertex writes, fires point queries, and checks each
// inside/outer/hole verdict against an in-bench even-odd crossing predictor.
// Runs several ring_count settings with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_with_holes;
   import pip_pkg::*;

   localparam int          RING_LIMIT     = 8;
   localparam int          RING_SLOTS     = 64;
   localparam int          STORE_DEPTH    = RING_LIMIT * RING_SLOTS;
   localparam int          COORD_MIN      = -32768;
   localparam int          COORD_MAX      = 32767;
   localparam int          PHASES         = 6;
   localparam int unsigned PHASE_ITEMS    = 180;
   localparam int unsigned SETTLE_CYCLES  = 24;
   localparam int unsigned BACKLOG_CYCLES = 400;
   localparam int unsigned CYCLE_LIMIT    = 3_000_000;

   // Holds the bench's own copy of the vertex store, ring lengths and
   // ring_count, and the verdicts still owed by the block.
   class polygon_tracker;
      int          vert_x[STORE_DEPTH];
      int          vert_y[STORE_DEPTH];
      int unsigned ring_len[RING_LIMIT];
      logic [3:0]  ring_count;
      rsp_type     verdicts[$];
      int unsigned mismatches;

      function new();
         foreach (ring_len[i]) ring_len[i] = 0;
         foreach (vert_x[i]) begin
            vert_x[i] = 0;
            vert_y[i] = 0;
         end
         ring_count = 4'd1;
         mismatches = 0;
      endfunction

      function void set_ring_count(logic [3:0] value);
         ring_count = value;
      endfunction

      function int unsigned outstanding();
         return verdicts.size();
      endfunction

      // Even-odd crossing parity of a horizontal ray to the right of the point.
      function bit crossing_odd(int unsigned r, longint px, longint py);
         int unsigned n, base, i, j;
         longint      x1, y1, x2, y2, lo, hi, d, t;
         bit          odd;
         n    = ring_len[r];
         base = r * RING_SLOTS;
         odd  = 1'b0;
         for (i = 0; i < n; i++) begin
            j  = (i + 1 == n) ? 0 : i + 1;
            x1 = vert_x[base + i];
            y1 = vert_y[base + i];
            x2 = vert_x[base + j];
            y2 = vert_y[base + j];
            if (y1 == y2) continue;
            lo = (y1 < y2) ? y1 : y2;
            hi = (y1 < y2) ? y2 : y1;
            // half-open y span: bottom end counts, top end does not
            if (py < lo || py >= hi) continue;
            d = y2 - y1;
            t = (x1 - px) * d + (x2 - x1) * (py - y1);
            if (d > 0 ? t > 0 : t < 0) odd = !odd;
         end
         return odd;
      endfunction

      function void note_request(req_type item);
         int unsigned slot, rings, r;
         bit          outer, hole;
         rsp_type     verdict;
         if (item.mode == MODE_WRITE) begin
            slot = int'(item.ring) * RING_SLOTS + int'(item.vertex_index);
            vert_x[slot] = int'($signed(item.coord_x));
            vert_y[slot] = int'($signed(item.coord_y));
            if (item.last_vertex) ring_len[item.ring] = int'(item.vertex_index) + 1;
         end else begin
            // zero acts as one ring, anything past the store saturates
            rings = (ring_count == 0) ? 1 :
                    (ring_count > RING_LIMIT) ? RING_LIMIT : int'(ring_count);
            outer = crossing_odd(0, $signed(item.coord_x), $signed(item.coord_y));
            hole  = 1'b0;
            for (r = 1; r < rings; r++)
               if (crossing_odd(r, $signed(item.coord_x), $signed(item.coord_y)))
                  hole = 1'b1;
            verdict.inside_res = outer && !hole;
            verdict.in_outer   = outer;
            verdict.in_hole    = hole;
            verdicts = {verdicts, verdict};
         end
      endfunction

      function void compare_flag(string name, logic want, logic got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %b, got %b", $time, name, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (verdicts.size() == 0) begin
            mismatches++;
            $display("%0t: result with no query waiting, expected none, got %b",
                     $time, got);
            return;
         end
         want = verdicts.pop_front();
         compare_flag("inside_res", want.inside_res, got.inside_res);
         compare_flag("in_outer", want.in_outer, got.in_outer);
         compare_flag("in_hole", want.in_hole, got.in_hole);
      endfunction
   endclass

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   req_type    req_data    = '0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en   = 1'b0;
   logic [3:0] csr_wr_data = 4'd0;

   // Shared stimulus knobs: calm_stretch turns off idling on both sides,
   // backlog_go asks the result side for one long hold-off.
   logic calm_stretch = 1'b0;
   logic backlog_go   = 1'b0;

   polygon_tracker board;
   int unsigned    items_sent  = 0;
   int unsigned    cycle_count = 0;
   bit             written[STORE_DEPTH];
   vtx_type        recent_points[$];

   point_in_polygon_with_holes #(
      .MAX_RINGS     (RING_LIMIT),
      .MAX_RING_VERTS(RING_SLOTS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #4 clock = ~clock;

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog: a correct run finishes far below this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Check every result taken by the bench.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   // Result side: random stalls, plus one long hold-off so that the block
   // backs up and stalls its request channel.
   initial begin : result_side
      int unsigned held;
      bit          backlog_done;
      backlog_done = 1'b0;
      forever begin
         @(posedge clock);
         if (backlog_go && !backlog_done) begin
            backlog_done = 1'b1;
            rsp_stall <= 1'b1;
            for (held = 0; held < BACKLOG_CYCLES; held++) @(posedge clock);
         end
         rsp_stall <= !calm_stretch && ($urandom_range(0, 99) < 15);
      end
   end

   function automatic req_type make_write(int r, int pos, bit last, int x, int y);
      req_type item;
      item.mode         = MODE_WRITE;
      item.ring         = 3'(r);
      item.vertex_index = 6'(pos);
      item.last_vertex  = last;
      item.coord_x      = coord_type'(x);
      item.coord_y      = coord_type'(y);
      return item;
   endfunction

   // Ring, position and last flag do not matter on a query: randomize them.
   function automatic req_type make_query(int x, int y);
      req_type item;
      item.mode         = MODE_QUERY;
      item.ring         = 3'($urandom);
      item.vertex_index = 6'($urandom);
      item.last_vertex  = 1'($urandom);
      item.coord_x      = coord_type'(x);
      item.coord_y      = coord_type'(y);
      return item;
   endfunction

   // Mostly within +/- span of the origin, now and then anywhere.
   function automatic int pick_coord(int span);
      if ($urandom_range(0, 19) == 0) return int'($signed(coord_type'($urandom)));
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Setting a ring length is legal only once every lower slot holds a vertex.
   function automatic bit prefix_ready(int r, int pos);
      for (int k = 0; k < pos; k++)
         if (!written[r * RING_SLOTS + k]) return 1'b0;
      return 1'b1;
   endfunction

   // Offer one request, hold it until taken, then record it.
   task automatic send_request(input req_type item);
      vtx_type point;
      if (!calm_stretch && $urandom_range(0, 99) < 5) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(item);
      items_sent++;
      if (item.mode == MODE_WRITE) begin
         written[int'(item.ring) * RING_SLOTS + int'(item.vertex_index)] = 1'b1;
         point.x = item.coord_x;
         point.y = item.coord_y;
         recent_points = {recent_points, point};
         if (recent_points.size() > 32) void'(recent_points.pop_front());
      end
   endtask

   task automatic write_ring_count(input logic [3:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_ring_count(value);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   // Drain, then let trailing vertex writes retire before touching the CSR.
   task automatic settle();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Load one ring in order; now and then cut it short without a last flag.
   task automatic load_ring(input int r, input int span);
      int unsigned roll, len, k;
      int          reach;
      bit          cut;
      roll  = $urandom_range(0, 99);
      len   = (roll < 5) ? $urandom_range(1, 2) :
              (roll < 9) ? $urandom_range(30, RING_SLOTS) : $urandom_range(3, 10);
      cut   = ($urandom_range(0, 9) == 0);
      reach = (r == 0) ? span : (span / 3 + 1);
      for (k = 0; k < len; k++)
         send_request(make_write(r, k, (k == len - 1) && !cut,
                                 pick_coord(reach), pick_coord(reach)));
   endtask

   task automatic run_phase(input int span, input bit pause_midway);
      int unsigned target, roll, pick_a, pick_b;
      int          r, pos;
      bit          paused;
      target = items_sent + PHASE_ITEMS;
      paused = 1'b0;
      while (items_sent < target) begin
         if (pause_midway && !paused && items_sent >= target - PHASE_ITEMS / 2) begin
            paused = 1'b1;
            wait_for_results();
         end
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            r = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, RING_LIMIT - 1);
            load_ring(r, span);
         end else if (roll < 20) begin
            // stray write anywhere in the store
            r   = $urandom_range(0, RING_LIMIT - 1);
            pos = $urandom_range(0, RING_SLOTS - 1);
            send_request(make_write(r, pos, $urandom_range(0, 1) && prefix_ready(r, pos),
                                    pick_coord(span), pick_coord(span)));
         end else if (roll < 36 && recent_points.size() != 0) begin
            // line the point up with stored vertices to hit edge and vertex ties
            pick_a = $urandom_range(0, recent_points.size() - 1);
            pick_b = $urandom_range(0, recent_points.size() - 1);
            send_request(make_query(int'($signed(recent_points[pick_a].x)),
                                    int'($signed(recent_points[pick_b].y))));
         end else begin
            send_request(make_query(pick_coord(span), pick_coord(span)));
         end
      end
   endtask

   initial begin : stimulus
      logic [3:0] phase_rings[PHASES];
      int         phase_span[PHASES];
      int         p;
      phase_rings = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd5, 4'd3};
      phase_span  = '{2000, 200, 4000, COORD_MAX, 500, COORD_MAX};
      board = new();
      do @(posedge clock); while (reset);

      // Directed part: 15 saturates to all eight rings.
      write_ring_count(4'd15);
      send_request(make_query(0, 0));                 // nothing loaded yet
      // outer ring: full-range square
      send_request(make_write(0, 0, 1'b0, COORD_MIN, COORD_MIN));
      send_request(make_write(0, 1, 1'b0, COORD_MAX, COORD_MIN));
      send_request(make_write(0, 2, 1'b0, COORD_MAX, COORD_MAX));
      send_request(make_write(0, 3, 1'b1, COORD_MIN, COORD_MAX));
      // hole triangle around the origin
      send_request(make_write(1, 0, 1'b0, -100, -100));
      send_request(make_write(1, 1, 1'b0, 100, -100));
      send_request(make_write(1, 2, 1'b1, 0, 100));
      // single-vertex and two-vertex rings: always an even count
      send_request(make_write(2, 0, 1'b1, 5, 5));
      send_request(make_write(3, 0, 1'b0, -50, -50));
      send_request(make_write(3, 1, 1'b1, 50, 50));
      // top slot of the last ring, length left at zero
      send_request(make_write(7, RING_SLOTS - 1, 1'b0, COORD_MAX, COORD_MIN));
      send_request(make_query(0, 0));                 // inside the hole
      send_request(make_query(200, 0));               // inside, clear of the hole
      send_request(make_query(0, -100));              // on the hole's flat bottom
      send_request(make_query(0, 100));               // on the hole's apex
      send_request(make_query(COORD_MAX, 0));         // on the right edge
      send_request(make_query(COORD_MIN, 0));         // on the left edge
      send_request(make_query(0, COORD_MAX));         // top y: half-open span excludes
      send_request(make_query(COORD_MIN, COORD_MIN)); // corner vertex
      send_request(make_query(5, 5));                 // on the lone vertex
      settle();

      // Random phases, each under its own ring_count. Phase 2 runs with no
      // idling, phase 3 carries the long result hold-off, phase 4 pauses
      // halfway until every verdict is back.
      for (p = 0; p < PHASES; p++) begin
         calm_stretch <= (p == 2);
         backlog_go   <= (p == 3);
         write_ring_count((p == 4) ? 4'($urandom_range(2, 7)) : phase_rings[p]);
         run_phase(phase_span[p], p == 4);
         settle();
      end

      if (board.mismatches == 0 && board.outstanding() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/pip_pkg.sv
hdl/pip_vram.sv
hdl/pip_xing.sv
hdl/point_in_polygon_with_holes.sv
hdl/pip_check.sv
tb/tb_point_in_polygon_with_holes.sv
